// ----- rtl/selt_pkg.sv -----
// shared types, widths and codes of the shared/exclusive lock table
package selt_pkg;

   localparam int SELT_MAX_ENTRIES  = 64;
   localparam int SELT_OWNER_BUDGET = 8;

   localparam int KEY_W   = 32;
   localparam int TXN_W   = 32;
   localparam int OWN_W   = 4;
   localparam int TOTAL_W = 7;

   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   function automatic int selt_clog2(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

// ----- rtl/selt_ram.sv -----
// generic single write port ram with registered read
module selt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/selt_cmp.sv -----
// shared 32-bit equality compare used for row keys and owner ids
module selt_cmp
   import selt_pkg::*;
(
   input  logic [KEY_W-1:0] a,
   input  logic [KEY_W-1:0] b,
   output logic             eq
);

   logic [KEY_W-1:0] diff;

   assign diff = a ^ b;
   assign eq   = ~|diff;

endmodule

// ----- rtl/shared_exclusive_lock_table_core.sv -----
// shared/exclusive row lock table: sequencer, entry and owner rams, shared compare
// acquire: key scan, owner base, decide; release adds an owner search, a gap fill and a finish step,
// and when the row empties the last entry and its owners move into the hole
// one request at a time: busy stays high until the cycle of the rsp_valid strobe;
// the number of steps is set by the one read port of each ram and the single compare unit
// synchronous reset empties the table at once; no clearing pass, the receiver cannot stall
module shared_exclusive_lock_table_core
   import selt_pkg::*;
#(
   parameter int MAX_ENTRIES  = SELT_MAX_ENTRIES,
   parameter int OWNER_BUDGET = SELT_OWNER_BUDGET
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic [KEY_W-1:0]   req_row_id,
   input  logic               req_want_exclusive,
   input  logic [TXN_W-1:0]   req_txn_id,
   input  logic               req_txn_aborted,
   input  logic               req_txn_holds_row,
   output logic               rsp_valid,
   output logic               rsp_success,
   output logic [OWN_W-1:0]   rsp_owner_count,
   output logic [TOTAL_W-1:0] rsp_entry_total
);

   // widths that follow from the table size
   localparam int EIW    = selt_clog2(MAX_ENTRIES);
   localparam int ECW    = $clog2(MAX_ENTRIES + 1);
   localparam int CW     = $clog2(OWNER_BUDGET + 1);
   localparam int ODEPTH = MAX_ENTRIES * OWNER_BUDGET;
   localparam int OAW    = selt_clog2(ODEPTH);
   localparam int EW     = KEY_W + 1 + CW;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_BASE,
      S_DECIDE,
      S_OREAD,
      S_OCMP,
      S_LREAD,
      S_LWRITE,
      S_FIN,
      S_EREAD,
      S_EWRITE,
      S_CREAD,
      S_CWRITE
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic             op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             excl_ff, excl_in;
   logic [TXN_W-1:0] txn_ff, txn_in;
   logic             abort_ff, abort_in;
   logic             holds_ff, holds_in;

   // table control
   logic [ECW-1:0]   count_ff, count_in;
   logic [EIW-1:0]   idx_ff, idx_in;
   logic             hit_ff, hit_in;
   logic [EIW-1:0]   eidx_ff, eidx_in;
   logic [CW-1:0]    ecnt_ff, ecnt_in;
   logic             eexcl_ff, eexcl_in;
   logic [OAW-1:0]   base_ff, base_in;
   logic [OAW-1:0]   src_ff, src_in;
   logic [CW-1:0]    j_ff, j_in;

   // result registers
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff, rsp_ok_in;
   logic [CW-1:0]    rsp_own_ff, rsp_own_in;
   logic [ECW-1:0]   rsp_total_ff;

   // ram ports
   logic             ent_we;
   logic [EIW-1:0]   ent_waddr, ent_raddr;
   logic [EW-1:0]    ent_wdata, ent_rdata;
   logic             own_we;
   logic [OAW-1:0]   own_waddr, own_raddr;
   logic [KEY_W-1:0] own_wdata, own_rdata;

   // decoded entry word: key, exclusive flag, owner count
   logic [KEY_W-1:0] rd_key;
   logic             rd_excl;
   logic [CW-1:0]    rd_cnt;

   // shared compare and the one small address multiplier
   logic [KEY_W-1:0] cmp_a, cmp_b;
   logic             cmp_eq;
   logic [EIW-1:0]   last_idx;
   logic [EIW-1:0]   e_sel;
   logic [EIW-1:0]   mul_sel;
   logic [OAW-1:0]   mul_prod;

   assign rd_key  = ent_rdata[EW-1 -: KEY_W];
   assign rd_excl = ent_rdata[CW];
   assign rd_cnt  = ent_rdata[CW-1:0];

   // compare serves the key scan and the owner search
   assign cmp_a = (state_ff == S_OCMP) ? own_rdata : rd_key;
   assign cmp_b = (state_ff == S_OCMP) ? txn_ff : key_ff;

   selt_cmp u_cmp (
      .a  (cmp_a),
      .b  (cmp_b),
      .eq (cmp_eq)
   );

   // last valid entry, source of the hole fill on removal
   logic [ECW-1:0] count_dec;
   assign count_dec = count_ff - ECW'(1);
   assign last_idx  = count_dec[EIW-1:0];
   // found entry, or the append slot when the row is absent
   assign e_sel     = hit_ff ? eidx_ff : count_ff[EIW-1:0];
   assign mul_sel   = (state_ff == S_EREAD) ? last_idx : e_sel;
   assign mul_prod  = OAW'(mul_sel) * OAW'(OWNER_BUDGET);

   selt_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   selt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (ODEPTH)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_waddr),
      .wr_data (own_wdata),
      .rd_addr (own_raddr),
      .rd_data (own_rdata)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      excl_in      = excl_ff;
      txn_in       = txn_ff;
      abort_in     = abort_ff;
      holds_in     = holds_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      eidx_in      = eidx_ff;
      ecnt_in      = ecnt_ff;
      eexcl_in     = eexcl_ff;
      base_in      = base_ff;
      src_in       = src_ff;
      j_in         = j_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_own_in   = ecnt_ff;

      ent_we    = 1'b0;
      ent_waddr = eidx_ff;
      ent_wdata = {key_ff, 1'b0, ecnt_ff};
      ent_raddr = '0;
      own_we    = 1'b0;
      own_waddr = base_ff + OAW'(j_ff);
      own_wdata = txn_ff;
      own_raddr = base_ff + OAW'(j_ff);

      case (state_ff)
         S_IDLE: begin
            ent_raddr = '0;
            if (start) begin
               op_in    = req_operation;
               key_in   = req_row_id;
               excl_in  = req_want_exclusive;
               txn_in   = req_txn_id;
               abort_in = req_txn_aborted;
               holds_in = req_txn_holds_row;
               idx_in   = '0;
               hit_in   = 1'b0;
               state_in = (count_ff == '0) ? S_BASE : S_SCAN;
            end
         end

         // one key per cycle, read of the next entry already in flight
         S_SCAN: begin
            ent_raddr = idx_ff + EIW'(1);
            if (cmp_eq) begin
               hit_in   = 1'b1;
               eidx_in  = idx_ff;
               ecnt_in  = rd_cnt;
               eexcl_in = rd_excl;
               state_in = S_BASE;
            end else if ((ECW'(idx_ff) + ECW'(1)) < count_ff) begin
               idx_in = idx_ff + EIW'(1);
            end else begin
               state_in = S_BASE;
            end
         end

         S_BASE: begin
            base_in = mul_prod;
            if (!hit_ff) begin
               eidx_in  = count_ff[EIW-1:0];
               ecnt_in  = '0;
               eexcl_in = 1'b0;
            end
            state_in = S_DECIDE;
         end

         S_DECIDE: begin
            if (op_ff == OP_ACQUIRE) begin
               if (abort_ff || (!hit_ff && (count_ff == ECW'(MAX_ENTRIES)))) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else if (excl_ff) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (ecnt_ff == '0) begin
                     ent_we     = 1'b1;
                     ent_wdata  = {key_ff, 1'b1, CW'(1)};
                     own_we     = 1'b1;
                     own_waddr  = base_ff;
                     count_in   = count_ff + ECW'(!hit_ff);
                     rsp_ok_in  = 1'b1;
                     rsp_own_in = CW'(1);
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (!eexcl_ff && (ecnt_ff < CW'(OWNER_BUDGET))) begin
                     ent_we     = 1'b1;
                     ent_wdata  = {key_ff, 1'b0, ecnt_ff + CW'(1)};
                     own_we     = 1'b1;
                     own_waddr  = base_ff + OAW'(ecnt_ff);
                     count_in   = count_ff + ECW'(!hit_ff);
                     rsp_ok_in  = 1'b1;
                     rsp_own_in = ecnt_ff + CW'(1);
                  end
               end
            end else begin
               if (!holds_ff || !hit_ff) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  j_in     = '0;
                  state_in = (ecnt_ff == '0) ? S_FIN : S_OREAD;
               end
            end
         end

         // owner search: read an owner, then compare it with the transaction id
         S_OREAD: begin
            own_raddr = base_ff + OAW'(j_ff);
            state_in  = S_OCMP;
         end

         S_OCMP: begin
            if (cmp_eq) begin
               state_in = S_LREAD;
            end else if ((j_ff + CW'(1)) < ecnt_ff) begin
               j_in     = j_ff + CW'(1);
               state_in = S_OREAD;
            end else begin
               state_in = S_FIN;
            end
         end

         // last owner moves into the gap
         S_LREAD: begin
            own_raddr = base_ff + OAW'(ecnt_ff - CW'(1));
            state_in  = S_LWRITE;
         end

         S_LWRITE: begin
            own_we    = 1'b1;
            own_waddr = base_ff + OAW'(j_ff);
            own_wdata = own_rdata;
            ent_we    = 1'b1;
            ent_wdata = {key_ff, 1'b0, ecnt_ff - CW'(1)};
            ecnt_in   = ecnt_ff - CW'(1);
            eexcl_in  = 1'b0;
            state_in  = S_FIN;
         end

         S_FIN: begin
            if (ecnt_ff == '0) begin
               if (ECW'(eidx_ff) == count_dec) begin
                  count_in     = count_dec;
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rsp_own_in   = '0;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_EREAD;
               end
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         // last entry fills the hole of the removed one
         S_EREAD: begin
            ent_raddr = last_idx;
            src_in    = mul_prod;
            state_in  = S_EWRITE;
         end

         S_EWRITE: begin
            ent_we    = 1'b1;
            ent_wdata = ent_rdata;
            ecnt_in   = rd_cnt;
            j_in      = '0;
            if (rd_cnt == '0) begin
               count_in     = count_dec;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_own_in   = '0;
               state_in     = S_IDLE;
            end else begin
               state_in = S_CREAD;
            end
         end

         S_CREAD: begin
            own_raddr = src_ff + OAW'(j_ff);
            state_in  = S_CWRITE;
         end

         S_CWRITE: begin
            own_we    = 1'b1;
            own_waddr = base_ff + OAW'(j_ff);
            own_wdata = own_rdata;
            if ((j_ff + CW'(1)) < ecnt_ff) begin
               j_in     = j_ff + CW'(1);
               state_in = S_CREAD;
            end else begin
               count_in     = count_dec;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_own_in   = '0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, table count and result strobe; payload registers need no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff    <= op_in;
      key_ff   <= key_in;
      excl_ff  <= excl_in;
      txn_ff   <= txn_in;
      abort_ff <= abort_in;
      holds_ff <= holds_in;
      idx_ff   <= idx_in;
      hit_ff   <= hit_in;
      eidx_ff  <= eidx_in;
      ecnt_ff  <= ecnt_in;
      eexcl_ff <= eexcl_in;
      base_ff  <= base_in;
      src_ff   <= src_in;
      j_ff     <= j_in;
      if (rsp_valid_in) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_own_ff   <= rsp_own_in;
         rsp_total_ff <= count_in;
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_ok_ff;
   assign rsp_owner_count = OWN_W'(rsp_own_ff);
   assign rsp_entry_total = TOTAL_W'(rsp_total_ff);

`ifndef NO_ASSERTIONS
   // result transfer only comes once the sequencer is back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // table never holds more rows than it has slots
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ECW'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   // an accepted request always occupies the sequencer
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but sequencer idle");

   // entry count changes only together with a finishing step that sets the result strobe
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (rsp_valid_in == 1'b1 || $past(rsp_valid_in) == 1'b1
                              || state_ff == S_IDLE))
      else $error("entry count changed outside a finishing step");
`endif

endmodule
